FILE: rtl/core/pixel_format_converter_defines.svh
// ----------------------------------------------------------------------------
// Pixel format converter assertion macros
// Clocked, reset-qualified property wrappers shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_DEFINES_SVH

// Same-cycle implication on clk_i, disabled while rst_ni is low.
`define PFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on clk_i, disabled while rst_ni is low.
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pfc_pkg.sv
// ----------------------------------------------------------------------------
// Pixel format converter package
// Format codes and configuration register indexes.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam logic [3:0] FMT_I8  = 4'd0;
  localparam logic [3:0] FMT_U8  = 4'd1;
  localparam logic [3:0] FMT_I16 = 4'd2;
  localparam logic [3:0] FMT_U16 = 4'd3;
  localparam logic [3:0] FMT_I32 = 4'd4;
  localparam logic [3:0] FMT_U32 = 4'd5;
  localparam logic [3:0] FMT_F16 = 4'd6;
  localparam logic [3:0] FMT_F32 = 4'd7;
  localparam logic [3:0] FMT_F64 = 4'd8;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SRC  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DST  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NORM = 2'd2;

  localparam int unsigned NumStages = 7;

endpackage

FILE: rtl/core/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// Pixel format converter
// Converts one channel value between integer and IEEE float formats through
// a binary64 intermediate, rounded only for normalized sources, in a seven stage pipeline.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  --------+-------------------------------------------+-----------------
//  input   | in_valid_i, in_stall_o, source_bits_i     | source value
//  output  | out_valid_o, out_stall_i, result_bits_o,  | converted value
//          | saturated_o                               |
//  config  | cfg_we_i, cfg_index_i, cfg_wdata_i        | register writes
//
//  One transaction per cycle while the output is not stalled; the pipeline is
//  made up of the load (decode, leading-zero count, shift and round) and store
//  (float round, second round for half) stages.
//  Reset clears the stage valid bits and loads the configuration defaults.
//  A stall on the output freezes every stage while out_valid_o is high; input stall follows it.
// ----------------------------------------------------------------------------
`include "pixel_format_converter_defines.svh"

module pixel_format_converter
  import pfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [63:0]        source_bits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        result_bits_o,
  output logic               saturated_o
);

  logic [3:0] src_q, dst_q;
  logic       norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= FMT_U8;
      dst_q  <= FMT_U8;
      norm_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SRC:  src_q  <= cfg_wdata_i;
        CFG_DST:  dst_q  <= cfg_wdata_i;
        CFG_NORM: norm_q <= cfg_wdata_i[0];
        default:  ;
      endcase
    end
  end

  logic                 en;
  logic [NumStages-1:0] vld_q;

  assign en          = !(vld_q[NumStages-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // Stage 1: decode the source into sign, significand and exponent base.
  logic               sp_d, s_d, stk_d;
  logic [63:0]        spw_d;
  logic [127:0]       m_d;
  logic signed [11:0] eb_d;
  logic signed [32:0] sv, negv;
  logic [31:0]        mag;
  logic               is_int;

  always_comb begin
    sp_d   = 1'b0;
    spw_d  = '0;
    s_d    = 1'b0;
    m_d    = '0;
    eb_d   = '0;
    stk_d  = 1'b0;
    sv     = '0;
    is_int = 1'b0;
    unique case (src_q)
      FMT_I8: begin
        sv = {{25{source_bits_i[7]}}, source_bits_i[7:0]};
        is_int = 1'b1;
      end
      FMT_U8: begin
        if (norm_q) begin
          if (source_bits_i[7:0] == 8'h00) begin
            sp_d = 1'b1;
          end else if (source_bits_i[7:0] == 8'hFF) begin
            sp_d  = 1'b1;
            spw_d = 64'h3FF0_0000_0000_0000;
          end else begin
            // x/255 is the byte repeated forever after the binary point
            m_d   = {16{source_bits_i[7:0]}};
            eb_d  = -12'sd64;
            stk_d = 1'b1;
          end
        end else begin
          sv = {25'b0, source_bits_i[7:0]};
          is_int = 1'b1;
        end
      end
      FMT_I16: begin
        sv = {{17{source_bits_i[15]}}, source_bits_i[15:0]};
        is_int = 1'b1;
      end
      FMT_U16: begin
        if (norm_q) begin
          if (source_bits_i[15:0] == 16'h0000) begin
            sp_d = 1'b1;
          end else if (source_bits_i[15:0] == 16'hFFFF) begin
            sp_d  = 1'b1;
            spw_d = 64'h3FF0_0000_0000_0000;
          end else begin
            m_d   = {8{source_bits_i[15:0]}};
            eb_d  = -12'sd64;
            stk_d = 1'b1;
          end
        end else begin
          sv = {17'b0, source_bits_i[15:0]};
          is_int = 1'b1;
        end
      end
      FMT_I32: begin
        sv = {source_bits_i[31], source_bits_i[31:0]};
        is_int = 1'b1;
      end
      FMT_U32: begin
        sv = {1'b0, source_bits_i[31:0]};
        is_int = 1'b1;
      end
      FMT_F16: begin
        s_d = source_bits_i[15];
        if (source_bits_i[14:10] == 5'h1F) begin
          sp_d  = 1'b1;
          spw_d = {source_bits_i[15], 11'h7FF,
                   (source_bits_i[9:0] == 10'd0) ? 52'd0
                                                 : {1'b1, source_bits_i[8:0], 42'd0}};
        end else if (source_bits_i[14:0] == 15'd0) begin
          sp_d  = 1'b1;
          spw_d = {source_bits_i[15], 63'd0};
        end else if (source_bits_i[14:10] == 5'd0) begin
          m_d  = {54'd0, source_bits_i[9:0], 64'd0};
          eb_d = -12'sd24;
        end else begin
          m_d  = {53'd0, 1'b1, source_bits_i[9:0], 64'd0};
          eb_d = $signed({7'd0, source_bits_i[14:10]}) - 12'sd25;
        end
      end
      FMT_F32: begin
        s_d = source_bits_i[31];
        if (source_bits_i[30:23] == 8'hFF) begin
          sp_d  = 1'b1;
          spw_d = {source_bits_i[31], 11'h7FF,
                   (source_bits_i[22:0] == 23'd0) ? 52'd0
                                                  : {1'b1, source_bits_i[21:0], 29'd0}};
        end else if (source_bits_i[30:0] == 31'd0) begin
          sp_d  = 1'b1;
          spw_d = {source_bits_i[31], 63'd0};
        end else if (source_bits_i[30:23] == 8'd0) begin
          m_d  = {41'd0, source_bits_i[22:0], 64'd0};
          eb_d = -12'sd149;
        end else begin
          m_d  = {40'd0, 1'b1, source_bits_i[22:0], 64'd0};
          eb_d = $signed({4'd0, source_bits_i[30:23]}) - 12'sd150;
        end
      end
      FMT_F64: begin
        sp_d  = 1'b1;
        spw_d = source_bits_i;
      end
      default: begin
        sp_d = 1'b1;
      end
    endcase
    negv = -sv;
    mag  = sv[32] ? negv[31:0] : sv[31:0];
    if (is_int) begin
      s_d = sv[32];
      m_d = {32'd0, mag, 64'd0};
      if (mag == 32'd0) begin
        sp_d  = 1'b1;
        spw_d = '0;
      end
    end
  end

  logic               p1_sp_q, p1_s_q, p1_stk_q;
  logic [63:0]        p1_spw_q;
  logic [127:0]       p1_m_q;
  logic signed [11:0] p1_eb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_sp_q  <= sp_d;
      p1_s_q   <= s_d;
      p1_stk_q <= stk_d;
      p1_spw_q <= spw_d;
      p1_m_q   <= m_d;
      p1_eb_q  <= eb_d;
    end
  end

  // Stage 2: leading-zero count of the upper significand word.
  logic [5:0] lz_d;

  always_comb begin
    lz_d = '0;
    for (int i = 0; i < 64; i++) begin
      if (p1_m_q[64+i]) lz_d = 6'(63 - i);
    end
  end

  logic               p2_sp_q, p2_s_q, p2_stk_q;
  logic [63:0]        p2_spw_q;
  logic [127:0]       p2_m_q;
  logic signed [11:0] p2_eb_q;
  logic [5:0]         p2_lz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_sp_q  <= p1_sp_q;
      p2_s_q   <= p1_s_q;
      p2_stk_q <= p1_stk_q;
      p2_spw_q <= p1_spw_q;
      p2_m_q   <= p1_m_q;
      p2_eb_q  <= p1_eb_q;
      p2_lz_q  <= lz_d;
    end
  end

  // Stage 3: normalize, round to binary64 and pack the intermediate.
  logic [127:0]       sh;
  logic               l_grd, l_stk, l_up;
  logic signed [11:0] l_exp;
  logic [62:0]        l_sum;
  logic [63:0]        w_d;

  always_comb begin
    sh    = p2_m_q << p2_lz_q;
    l_grd = sh[74];
    l_stk = (|sh[73:64]) | p2_stk_q;
    l_up  = l_grd & (l_stk | sh[75]);
    l_exp = 12'sd1086 + p2_eb_q - $signed({6'd0, p2_lz_q});
    l_sum = {l_exp[10:0], sh[126:75]} + {62'd0, l_up};
    w_d   = p2_sp_q ? p2_spw_q : {p2_s_q, l_sum};
  end

  logic [63:0] p3_w_q;

  always_ff @(posedge clk_i) begin
    if (en) p3_w_q <= w_d;
  end

  // Stage 4: integer magnitude and first float narrowing shift.
  logic [10:0] ef3, esh, ftmp;
  logic [84:0] sl;
  logic [32:0] imag_d;
  logic        lt1_d, big_d, nan_d;
  logic [5:0]  fsh;
  logic [107:0] fext;

  always_comb begin
    ef3    = p3_w_q[62:52];
    lt1_d  = ef3 < 11'd1023;
    big_d  = ef3 >= 11'd1056;
    nan_d  = (ef3 == 11'h7FF) && (p3_w_q[51:0] != 52'd0);
    esh    = ef3 - 11'd1023;
    sl     = {32'd0, 1'b1, p3_w_q[51:0]} << esh[5:0];
    imag_d = lt1_d ? 33'd0 : sl[84:52];
    ftmp   = 11'd926 - ef3;
    fsh    = (ef3 < 11'd897) ? ftmp[5:0] : 6'd29;
    fext   = {1'b1, p3_w_q[51:0], 55'd0} >> fsh;
  end

  logic [63:0] p4_w_q;
  logic [32:0] p4_imag_q;
  logic        p4_lt1_q, p4_big_q, p4_nan_q, p4_fg_q, p4_fs_q;
  logic [23:0] p4_fq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_w_q    <= p3_w_q;
      p4_imag_q <= imag_d;
      p4_lt1_q  <= lt1_d;
      p4_big_q  <= big_d;
      p4_nan_q  <= nan_d;
      p4_fq_q   <= fext[78:55];
      p4_fg_q   <= fext[54];
      p4_fs_q   <= |fext[53:0];
    end
  end

  // Stage 5: integer saturation and binary32 rounding.
  logic        issgn, isat, sg4, fup;
  logic [32:0] hr, iv;
  logic [63:0] msk, ires, res5;
  logic [10:0] ef4;
  logic [24:0] fq25;
  logic [35:0] r36;
  logic [31:0] f32_d;

  always_comb begin
    sg4   = p4_w_q[63];
    ef4   = p4_w_q[62:52];
    issgn = 1'b0;
    hr    = 33'h1_0000_0000;
    msk   = 64'h0000_0000_FFFF_FFFF;
    case (dst_q)
      FMT_I8:  begin issgn = 1'b1; hr = 33'd128;         msk = 64'hFF;   end
      FMT_U8:  begin issgn = 1'b0; hr = 33'd256;         msk = 64'hFF;   end
      FMT_I16: begin issgn = 1'b1; hr = 33'd32768;       msk = 64'hFFFF; end
      FMT_U16: begin issgn = 1'b0; hr = 33'd65536;       msk = 64'hFFFF; end
      FMT_I32: begin issgn = 1'b1; hr = 33'h0_8000_0000; end
      default: ;
    endcase
    isat = 1'b0;
    if (p4_nan_q) begin
      iv   = '0;
      isat = 1'b1;
    end else if (issgn && !sg4) begin
      if (p4_big_q || p4_imag_q >= hr) begin iv = hr - 33'd1; isat = 1'b1; end
      else iv = p4_imag_q;
    end else if (issgn) begin
      if (p4_big_q || p4_imag_q > hr) begin iv = -hr; isat = 1'b1; end
      else iv = -p4_imag_q;
    end else if (sg4) begin
      // values in (-1,0) truncate to zero quietly
      iv   = '0;
      isat = !p4_lt1_q;
    end else begin
      if (p4_big_q || p4_imag_q >= hr) begin iv = hr - 33'd1; isat = 1'b1; end
      else iv = p4_imag_q;
    end
    ires = {31'd0, iv} & msk;

    fup  = p4_fg_q & (p4_fs_q | p4_fq_q[0]);
    fq25 = {1'b0, p4_fq_q} + {24'd0, fup};
    r36  = (({25'd0, ef4} - 36'd897) << 23) + {11'd0, fq25};
    if (ef4 == 11'h7FF) begin
      f32_d = (p4_w_q[51:0] == 52'd0) ? {sg4, 8'hFF, 23'd0}
                                      : {sg4, 8'hFF, 1'b1, p4_w_q[50:29]};
    end else if (ef4 < 11'd873) begin
      f32_d = {sg4, 31'd0};
    end else if (ef4 < 11'd897) begin
      f32_d = {sg4, 6'd0, fq25};
    end else if (r36 >= 36'h0_7F80_0000) begin
      f32_d = {sg4, 8'hFF, 23'd0};
    end else begin
      f32_d = {sg4, r36[30:0]};
    end

    case (dst_q) inside
      [FMT_I8:FMT_U32]: res5 = ires;
      FMT_F32: res5 = {32'd0, f32_d};
      FMT_F64: res5 = p4_w_q;
      default: res5 = '0;
    endcase
    if (dst_q > FMT_U32) isat = 1'b0;
  end

  logic [63:0] p5_res_q;
  logic [31:0] p5_f32_q;
  logic        p5_sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_res_q <= res5;
      p5_f32_q <= f32_d;
      p5_sat_q <= isat;
    end
  end

  // Stage 6: second narrowing shift, binary32 to binary16.
  logic [7:0]  hef5, htmp;
  logic [4:0]  hsh;
  logic [49:0] hext;

  always_comb begin
    hef5 = p5_f32_q[30:23];
    htmp = 8'd126 - hef5;
    hsh  = (hef5 < 8'd113) ? htmp[4:0] : 5'd13;
    hext = {1'b1, p5_f32_q[22:0], 26'd0} >> hsh;
  end

  logic [63:0] p6_res_q;
  logic [31:0] p6_f32_q;
  logic        p6_sat_q, p6_hg_q, p6_hs_q;
  logic [10:0] p6_hq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p6_res_q <= p5_res_q;
      p6_f32_q <= p5_f32_q;
      p6_sat_q <= p5_sat_q;
      p6_hq_q  <= hext[36:26];
      p6_hg_q  <= hext[25];
      p6_hs_q  <= |hext[24:0];
    end
  end

  // Stage 7: binary16 rounding and output select.
  logic        hsg, hup;
  logic [7:0]  hef6;
  logic [11:0] hq12;
  logic [19:0] r20;
  logic [15:0] h16;
  logic [63:0] res7;

  always_comb begin
    hsg  = p6_f32_q[31];
    hef6 = p6_f32_q[30:23];
    hup  = p6_hg_q & (p6_hs_q | p6_hq_q[0]);
    hq12 = {1'b0, p6_hq_q} + {11'd0, hup};
    r20  = (({12'd0, hef6} - 20'd113) << 10) + {8'd0, hq12};
    if (hef6 == 8'hFF) begin
      h16 = (p6_f32_q[22:0] == 23'd0) ? {hsg, 5'h1F, 10'd0}
                                      : {hsg, 5'h1F, 1'b1, p6_f32_q[21:13]};
    end else if (hef6 < 8'd102) begin
      h16 = {hsg, 15'd0};
    end else if (hef6 < 8'd113) begin
      h16 = {hsg, 3'd0, hq12};
    end else if (r20 >= 20'h07C00) begin
      h16 = {hsg, 5'h1F, 10'd0};
    end else begin
      h16 = {hsg, r20[14:0]};
    end
    res7 = (dst_q == FMT_F16) ? {48'd0, h16} : p6_res_q;
  end

  logic [63:0] out_res_q;
  logic        out_sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_q <= res7;
      out_sat_q <= p6_sat_q;
    end
  end

  assign result_bits_o = out_res_q;
  assign saturated_o   = out_sat_q;

  `PFC_ASSERT_NOW(a_sat_int_only, out_valid_o && saturated_o, dst_q <= FMT_U32, "saturation on float store")
  `PFC_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, vld_q[0], "accepted transaction lost")
  `PFC_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld_q), "pipeline moved under stall")
  `PFC_ASSERT_NOW(a_f32_upper_zero, out_valid_o && (dst_q == FMT_F32), result_bits_o[63:32] == 32'd0, "binary32 upper bits set")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel format converter testbench
// Checks every converted channel value against a bit-exact predictor of the
// load/store conversion, over directed corner values and random
// configurations, with random idle cycles and output stalls.
// ----------------------------------------------------------------------------

class conv_board;
  logic [3:0]  src_fmt;
  logic [3:0]  dst_fmt;
  logic        norm_en;
  logic [63:0] exp_bits[$];
  logic        exp_sat[$];
  int          mismatches;

  function new();
    src_fmt    = pfc_pkg::FMT_U8;
    dst_fmt    = pfc_pkg::FMT_U8;
    norm_en    = 1'b0;
    mismatches = 0;
  endfunction

  static function logic [63:0] ones(int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // Exact widening between float formats.
  static function logic [63:0] fp_widen(logic [63:0] x, int unsigned se, int unsigned sm,
                                        int unsigned de, int unsigned dm);
    longint      sbias, dbias, e;
    logic [63:0] ef, mf, dsign, dinf, sig;
    sbias = longint'(ones(se - 1));
    dbias = longint'(ones(de - 1));
    ef    = (x >> sm) & ones(se);
    mf    = x & ones(sm);
    dsign = ((x >> (se + sm)) & 64'd1) << (de + dm);
    dinf  = ones(de) << dm;
    if (ef == ones(se)) begin
      if (mf == 0) return dsign | dinf;
      return dsign | dinf | (64'd1 << (dm - 1)) | (mf << (dm - sm));
    end
    if (ef == 0 && mf == 0) return dsign;
    if (ef == 0) begin
      e   = 1 - sbias;
      sig = mf;
      while (((sig >> sm) & 64'd1) == 0) begin
        sig = sig << 1;
        e   = e - 1;
      end
    end else begin
      e   = longint'(ef) - sbias;
      sig = mf | (64'd1 << sm);
    end
    return dsign | (64'(e + dbias) << dm) | ((sig << (dm - sm)) & ones(dm));
  endfunction

  // Round-to-nearest-even narrowing between float formats.
  static function logic [63:0] fp_narrow(logic [63:0] x, int unsigned se, int unsigned sm,
                                         int unsigned de, int unsigned dm);
    longint      sbias, dbias, e, emin, shift;
    logic [63:0] ef, mf, dsign, dinf, sig, q, rem, hlf, r;
    sbias = longint'(ones(se - 1));
    dbias = longint'(ones(de - 1));
    emin  = 1 - dbias;
    ef    = (x >> sm) & ones(se);
    mf    = x & ones(sm);
    dsign = ((x >> (se + sm)) & 64'd1) << (de + dm);
    dinf  = ones(de) << dm;
    if (ef == ones(se)) begin
      if (mf == 0) return dsign | dinf;
      return dsign | dinf | (64'd1 << (dm - 1)) | (mf >> (sm - dm));
    end
    if (ef == 0 && mf == 0) return dsign;
    if (ef == 0) begin
      e   = 1 - sbias;
      sig = mf;
      while (((sig >> sm) & 64'd1) == 0) begin
        sig = sig << 1;
        e   = e - 1;
      end
    end else begin
      e   = longint'(ef) - sbias;
      sig = mf | (64'd1 << sm);
    end
    shift = longint'(sm) - longint'(dm);
    if (e < emin) begin
      if (emin - e > longint'(dm) + 2) return dsign;
      shift = shift + (emin - e);
    end
    if (shift > longint'(sm) + 1) return dsign;
    q   = sig >> shift;
    rem = sig & ones(int'(shift));
    hlf = 64'd1 << (shift - 1);
    if (rem > hlf || (rem == hlf && q[0])) q = q + 1;
    if (e < emin) return dsign | q;
    r = (64'(e + dbias) << dm) + q - (64'd1 << dm);
    if (r >= dinf) return dsign | dinf;
    return dsign | r;
  endfunction

  // Truncating integer store with saturation; NaN gives zero.
  static function logic [63:0] int_store(logic [63:0] w, real lo, real hi, longint minv,
                                         longint maxv, int unsigned width, ref logic sat);
    real    d, t;
    longint v;
    if (w[62:52] == 11'h7FF && w[51:0] != 0) begin
      sat = 1'b1;
      return 64'd0;
    end
    d = $bitstoreal(w);
    if (d <= lo) begin
      sat = 1'b1;
      v   = minv;
    end else if (d >= hi) begin
      sat = 1'b1;
      v   = maxv;
    end else begin
      t = (d < 0.0) ? -$floor(-d) : $floor(d);
      v = longint'(t);
    end
    return 64'(v) & ones(width);
  endfunction

  function void convert(logic [63:0] b, output logic [63:0] res, output logic sat);
    logic [63:0] w;
    w   = '0;
    sat = 1'b0;
    case (src_fmt)
      pfc_pkg::FMT_I8:  w = $realtobits(real'(longint'($signed(b[7:0]))));
      pfc_pkg::FMT_U8:  w = norm_en ? $realtobits(real'(longint'(b[7:0])) / 255.0)
                                    : $realtobits(real'(longint'(b[7:0])));
      pfc_pkg::FMT_I16: w = $realtobits(real'(longint'($signed(b[15:0]))));
      pfc_pkg::FMT_U16: w = norm_en ? $realtobits(real'(longint'(b[15:0])) / 65535.0)
                                    : $realtobits(real'(longint'(b[15:0])));
      pfc_pkg::FMT_I32: w = $realtobits(real'(longint'($signed(b[31:0]))));
      pfc_pkg::FMT_U32: w = $realtobits(real'(longint'(b[31:0])));
      pfc_pkg::FMT_F16: w = fp_widen({48'd0, b[15:0]}, 5, 10, 11, 52);
      pfc_pkg::FMT_F32: w = fp_widen({32'd0, b[31:0]}, 8, 23, 11, 52);
      pfc_pkg::FMT_F64: w = b;
      default:          w = '0;
    endcase
    case (dst_fmt)
      pfc_pkg::FMT_I8:  res = int_store(w, -129.0, 128.0, -128, 127, 8, sat);
      pfc_pkg::FMT_U8:  res = int_store(w, -1.0, 256.0, 0, 255, 8, sat);
      pfc_pkg::FMT_I16: res = int_store(w, -32769.0, 32768.0, -32768, 32767, 16, sat);
      pfc_pkg::FMT_U16: res = int_store(w, -1.0, 65536.0, 0, 65535, 16, sat);
      pfc_pkg::FMT_I32: res = int_store(w, -2147483649.0, 2147483648.0, -64'sd2147483648,
                                        64'sd2147483647, 32, sat);
      pfc_pkg::FMT_U32: res = int_store(w, -1.0, 4294967296.0, 0, 64'sd4294967295, 32, sat);
      pfc_pkg::FMT_F16: res = fp_narrow(fp_narrow(w, 11, 52, 8, 23), 8, 23, 5, 10);
      pfc_pkg::FMT_F32: res = fp_narrow(w, 11, 52, 8, 23);
      pfc_pkg::FMT_F64: res = w;
      default:          res = '0;
    endcase
  endfunction

  function void note_input(logic [63:0] b);
    logic [63:0] res;
    logic        sat;
    convert(b, res, sat);
    exp_bits.push_back(res);
    exp_sat.push_back(sat);
  endfunction

  function void check_result(logic [63:0] res, logic sat);
    logic [63:0] eb;
    logic        es;
    if (exp_bits.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h sat %b", res, sat);
      return;
    end
    eb = exp_bits.pop_front();
    es = exp_sat.pop_front();
    if (res !== eb || sat !== es) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: result %h sat %b, expected %h sat %b", res, sat, eb, es);
    end
  endfunction

  function int pending();
    return exp_bits.size();
  endfunction
endclass

module testbench;
  import pfc_pkg::*;

  localparam int unsigned StallLimit = 2000;

  typedef struct {
    logic [3:0]  src;
    logic [3:0]  dst;
    logic        norm;
    logic [63:0] val;
  } directed_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [3:0]         cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [63:0]        source_bits_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [63:0]        result_bits_o;
  logic               saturated_o;

  conv_board board = new();
  bit        no_idle = 1'b0;
  int        quiet_cycles = 0;

  pixel_format_converter DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Score accepted transactions on both channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_input(source_bits_i);
      if (out_valid_o && !out_stall_i) board.check_result(result_bits_o, saturated_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Output stall: random hold per result, released until a transaction moves.
  initial begin
    int gap;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
    end
  end

  // Drop the input, let the last transaction reach the board, then drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [3:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SRC:  board.src_fmt = val;
      CFG_DST:  board.dst_fmt = val;
      CFG_NORM: board.norm_en = val[0];
      default:  ;
    endcase
  endtask

  task automatic set_mode(logic [3:0] src, logic [3:0] dst, logic norm);
    wait_idle();
    cfg_write(CFG_SRC, src);
    cfg_write(CFG_DST, dst);
    // upper data bits of the flag register are don't-care
    cfg_write(CFG_NORM, {3'($urandom), norm});
  endtask

  task automatic send_item(logic [63:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    source_bits_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Random value with a bias toward the corners of the source format.
  function automatic logic [63:0] pick_value(logic [3:0] fmt);
    logic [63:0] b;
    logic [10:0] ex;
    int          r;
    b = {$urandom, $urandom};
    r = $urandom_range(0, 9);
    if (r < 4) return b;
    case (fmt)
      FMT_F16: begin
        ex = (r == 4) ? 11'h1F : (r == 5) ? 11'h0 : 11'($urandom_range(10, 20));
        b[14:10] = ex[4:0];
        if (r == 6) b[9:0] = '0;
      end
      FMT_F32: begin
        ex = (r == 4) ? 11'hFF : (r == 5) ? 11'h0 : 11'($urandom_range(100, 160));
        b[30:23] = ex[7:0];
        if (r == 6) b[22:0] = '0;
      end
      FMT_F64: begin
        if (r >= 7) begin
          b = $realtobits((real'($urandom) - 2147483648.0) * 2.0 +
                          real'($urandom_range(0, 1000)) / 1000.0);
        end else begin
          ex = (r == 4) ? 11'h7FF : (r == 5) ? 11'h0 : 11'($urandom_range(850, 1200));
          b[62:52] = ex;
          if (r == 6) b[51:0] = '0;
        end
      end
      default: begin
        case (r)
          4: b[31:0] = '0;
          5: b[31:0] = '1;
          6: b[31:0] = 32'h0000_0080;
          7: b[31:0] = 32'h0000_8000;
          8: b[31:0] = 32'h8000_0000;
          default: b[31:0] = 32'h7FFF_FFFF;
        endcase
      end
    endcase
    return b;
  endfunction

  directed_t corner[] = '{
    '{FMT_U8,  FMT_F64, 1'b1, 64'h0000_0000_0000_00FF},
    '{FMT_U8,  FMT_F32, 1'b1, 64'hFFFF_FFFF_FFFF_FF01},
    '{FMT_U16, FMT_F32, 1'b1, 64'h0000_0000_0000_FFFF},
    '{FMT_U16, FMT_F16, 1'b1, 64'h0000_0000_0000_1234},
    '{FMT_U16, FMT_U16, 1'b0, 64'h0000_0000_0000_FFFF},
    '{FMT_F64, FMT_I8,  1'b0, 64'h7FF8_0000_0000_0001},
    '{FMT_F64, FMT_U8,  1'b0, 64'hBFE0_0000_0000_0000},
    '{FMT_F64, FMT_I32, 1'b0, 64'h4202_A05F_2000_0000},
    '{FMT_F64, FMT_U32, 1'b0, 64'hFFF0_0000_0000_0000},
    '{FMT_F64, FMT_F16, 1'b0, 64'h40EF_FE00_0000_0000},
    '{FMT_F64, FMT_F32, 1'b0, 64'h36A0_0000_0000_0000},
    '{FMT_F64, FMT_F16, 1'b0, 64'h7FF0_0000_0000_0001},
    '{FMT_F64, FMT_F16, 1'b0, 64'hFFF0_0000_0000_0000},
    '{FMT_F16, FMT_F64, 1'b0, 64'h0000_0000_0000_7C01},
    '{FMT_F16, FMT_F64, 1'b0, 64'hFFFF_0000_0000_0001},
    '{FMT_F32, FMT_F64, 1'b0, 64'h0000_0000_8000_0001},
    '{FMT_F32, FMT_I16, 1'b0, 64'h0000_0000_7F80_0000},
    '{FMT_I8,  FMT_I16, 1'b0, 64'h0000_0000_0000_0080},
    '{FMT_I32, FMT_F32, 1'b0, 64'h0000_0000_7FFF_FFFF},
    '{FMT_U32, FMT_I32, 1'b0, 64'h0000_0000_FFFF_FFFF},
    '{FMT_I16, FMT_U16, 1'b0, 64'h0000_0000_0000_8000},
    '{4'd9,    FMT_F64, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
    '{FMT_F64, 4'd15,   1'b0, 64'h3FF0_0000_0000_0000}
  };

  initial begin
    logic [3:0] src, dst;
    int         sent, len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner[i]) begin
      if (i == 0 || corner[i].src != board.src_fmt || corner[i].dst != board.dst_fmt ||
          corner[i].norm != board.norm_en)
        set_mode(corner[i].src, corner[i].dst, corner[i].norm);
      send_item(corner[i].val);
    end

    // Random phases; each config change waits for the pipeline to drain.
    sent = 0;
    while (sent < 400) begin
      src = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      dst = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      set_mode(src, dst, 1'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      len = $urandom_range(5, 40);
      repeat (len) send_item(pick_value(src));
      sent += len;
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    wait_idle();
    repeat (NumStages + 8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
